### rtl/vns_pkg.sv
// Shared types and constants for the vector normalize and scale pipeline.
package vns_pkg;

  localparam logic OP_NORM  = 1'b0;
  localparam logic OP_SCALE = 1'b1;

  localparam logic [15:0] UNIT_LEN = 16'd4096;
  localparam logic [31:0] WIN_LO   = 32'd16687225;
  localparam logic [31:0] WIN_HI   = 32'd16851025;

  localparam int SQRT_CELLS = 16;
  localparam int DIV_CELLS  = 17;

  // Values that ride along the square root chain untouched.
  typedef struct packed {
    logic               op;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [31:0] xf;
    logic signed [31:0] yf;
    logic               win;
  } pass_t;

  // State of one square root cell: radicand bits still to consume,
  // partial remainder and partial root.
  typedef struct packed {
    logic [31:0] v;
    logic [17:0] rem;
    logic [15:0] root;
    pass_t       pass;
  } sqc_t;

  // One component inside the divider chain.
  typedef struct packed {
    logic [15:0] rem;
    logic [16:0] lo;
    logic [16:0] q;
    logic        neg;
    logic        ovf;
  } lane_t;

  typedef struct packed {
    lane_t       lx;
    lane_t       ly;
    logic [15:0] len;
    logic        zero;
  } dvc_t;

  // Magnitudes of the dividends after the length is known.
  typedef struct packed {
    logic [30:0] nx;
    logic [30:0] ny;
    logic        negx;
    logic        negy;
    logic [15:0] len;
    logic        zero;
  } num_t;

endpackage

### rtl/vns_sqrt_cell.sv
// One cell of the square root chain: settles one root bit per cell.
module vns_sqrt_cell (
  input  logic           clk,
  input  logic           en,
  input  vns_pkg::sqc_t  din,
  output vns_pkg::sqc_t  dout
);

  vns_pkg::sqc_t nxt;
  logic [19:0]   t;
  logic [19:0]   trial;

  always_comb begin
    t     = {din.rem, din.v[31:30]};
    trial = {2'b00, din.root, 2'b01};
    nxt      = din;
    nxt.v    = {din.v[29:0], 2'b00};
    if (t >= trial) begin
      nxt.rem  = 18'(t - trial);
      nxt.root = {din.root[14:0], 1'b1};
    end else begin
      nxt.rem  = t[17:0];
      nxt.root = {din.root[14:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= nxt;
    end
  end

endmodule

### rtl/vns_div_cell.sv
// One cell of the divider chain: one quotient bit for both components.
module vns_div_cell (
  input  logic           clk,
  input  logic           en,
  input  vns_pkg::dvc_t  din,
  output vns_pkg::dvc_t  dout
);

  vns_pkg::dvc_t nxt;

  function automatic vns_pkg::lane_t step(vns_pkg::lane_t l, logic [15:0] len);
    vns_pkg::lane_t r;
    logic [16:0]    t;
    r    = l;
    t    = {l.rem, l.lo[16]};
    r.lo = {l.lo[15:0], 1'b0};
    if (t >= {1'b0, len}) begin
      r.rem = 16'(t - {1'b0, len});
      r.q   = {l.q[15:0], 1'b1};
    end else begin
      r.rem = t[15:0];
      r.q   = {l.q[15:0], 1'b0};
    end
    return r;
  endfunction

  always_comb begin
    nxt    = din;
    nxt.lx = step(din.lx, din.len);
    nxt.ly = step(din.ly, din.len);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= nxt;
    end
  end

endmodule

### rtl/vector_normalize_scale.sv
// Top level: squares, square root cell chain, divider cell chain, saturation.
//
//  channel  | direction | tdata                           | tuser
//  s_*      | in        | vec_x, vec_y, factor            | opcode
//  m_*      | out       | out_x, out_y                    | zero_length, clipped
//
// One item per cycle is accepted unless the output is stalled with every stage
// full. The 39 stages are the input register, the products, the squared
// length, 16 square root cells, the length select, the divider entry,
// 17 divider cells and the output register.
// Every stage holds a valid bit and moves whenever the stage after it is
// empty or moving, so bubbles close up while the output is stalled.
// Reset clears the valid bits only.
module vector_normalize_scale (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // vec_x, vec_y, factor
  input  logic        s_tuser,   // opcode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // out_x, out_y
  output logic [1:0]  m_tuser    // zero_length, clipped
);

  localparam int SQ0  = 3;
  localparam int LENS = SQ0 + vns_pkg::SQRT_CELLS;
  localparam int DV0S = LENS + 1;
  localparam int DIV0 = DV0S + 1;
  localparam int OUTS = DIV0 + vns_pkg::DIV_CELLS;
  localparam int NST  = OUTS + 1;

  logic [NST-1:0] vld;
  logic [NST-1:0] en;

  always_comb begin
    en[NST-1] = !vld[NST-1] || m_tready;
    for (int i = NST - 2; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= s_tvalid;
      end
      for (int i = 1; i < NST; i++) begin
        if (en[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  assign s_tready = en[0];

  // Input register
  logic               op1;
  logic signed [15:0] x1, y1, f1;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      op1 <= s_tuser;
      x1  <= s_tdata[15:0];
      y1  <= s_tdata[31:16];
      f1  <= s_tdata[47:32];
    end
  end

  // Products
  logic [16:0]        ax, ay;
  logic [33:0]        ax2w, ay2w;
  logic [31:0]        ax2, ay2;
  logic signed [31:0] xf2, yf2;
  logic               op2;
  logic signed [15:0] x2, y2;

  assign ax   = x1[15] ? 17'(-{x1[15], x1}) : {1'b0, x1};
  assign ay   = y1[15] ? 17'(-{y1[15], y1}) : {1'b0, y1};
  assign ax2w = ax * ax;
  assign ay2w = ay * ay;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      ax2 <= ax2w[31:0];
      ay2 <= ay2w[31:0];
      xf2 <= x1 * f1;
      yf2 <= y1 * f1;
      op2 <= op1;
      x2  <= x1;
      y2  <= y1;
    end
  end

  // Squared length and unit window
  logic [31:0]   sq;
  vns_pkg::sqc_t sqc [0:vns_pkg::SQRT_CELLS];

  assign sq = ax2 + ay2;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      sqc[0].v        <= sq;
      sqc[0].rem      <= '0;
      sqc[0].root     <= '0;
      sqc[0].pass.op  <= op2;
      sqc[0].pass.x   <= x2;
      sqc[0].pass.y   <= y2;
      sqc[0].pass.xf  <= xf2;
      sqc[0].pass.yf  <= yf2;
      sqc[0].pass.win <= (op2 == vns_pkg::OP_SCALE) && (sq >= vns_pkg::WIN_LO)
                         && (sq <= vns_pkg::WIN_HI);
    end
  end

  for (genvar g = 0; g < vns_pkg::SQRT_CELLS; g++) begin : g_sqrt
    vns_sqrt_cell u_cell (
      .clk  (clk),
      .en   (en[SQ0+g]),
      .din  (sqc[g]),
      .dout (sqc[g+1])
    );
  end

  // Length select and dividend magnitudes
  vns_pkg::pass_t     ps;
  logic [15:0]        len;
  logic signed [32:0] nx, ny;
  vns_pkg::num_t      num;

  assign ps  = sqc[vns_pkg::SQRT_CELLS].pass;
  assign len = ps.win ? vns_pkg::UNIT_LEN : sqc[vns_pkg::SQRT_CELLS].root;

  always_comb begin
    if (ps.op == vns_pkg::OP_SCALE) begin
      nx = 33'(ps.xf) + 33'({1'b0, len[15:1]});
      ny = 33'(ps.yf) + 33'({1'b0, len[15:1]});
    end else begin
      nx = 33'(ps.x) <<< 12;
      ny = 33'(ps.y) <<< 12;
    end
  end

  always_ff @(posedge clk) begin
    if (en[LENS]) begin
      num.nx   <= nx[32] ? 31'(-nx) : nx[30:0];
      num.ny   <= ny[32] ? 31'(-ny) : ny[30:0];
      num.negx <= nx[32];
      num.negy <= ny[32];
      num.len  <= len;
      num.zero <= (len == '0);
    end
  end

  // Divider entry: quotients of 2^17 and more are flagged as overflow.
  vns_pkg::dvc_t dvc [0:vns_pkg::DIV_CELLS];

  always_ff @(posedge clk) begin
    if (en[DV0S]) begin
      dvc[0].len    <= num.len;
      dvc[0].zero   <= num.zero;
      dvc[0].lx.rem <= {2'b00, num.nx[30:17]};
      dvc[0].lx.lo  <= num.nx[16:0];
      dvc[0].lx.q   <= '0;
      dvc[0].lx.neg <= num.negx;
      dvc[0].lx.ovf <= {2'b00, num.nx[30:17]} >= num.len;
      dvc[0].ly.rem <= {2'b00, num.ny[30:17]};
      dvc[0].ly.lo  <= num.ny[16:0];
      dvc[0].ly.q   <= '0;
      dvc[0].ly.neg <= num.negy;
      dvc[0].ly.ovf <= {2'b00, num.ny[30:17]} >= num.len;
    end
  end

  for (genvar g = 0; g < vns_pkg::DIV_CELLS; g++) begin : g_div
    vns_div_cell u_cell (
      .clk  (clk),
      .en   (en[DIV0+g]),
      .din  (dvc[g]),
      .dout (dvc[g+1])
    );
  end

  // Sign and saturation
  vns_pkg::dvc_t dl;
  logic [15:0]   rx, ry;
  logic          cx, cy;

  assign dl = dvc[vns_pkg::DIV_CELLS];

  always_comb begin
    if (dl.lx.neg) begin
      cx = dl.lx.ovf || (dl.lx.q > 17'd32768);
      rx = cx ? 16'h8000 : 16'(-dl.lx.q);
    end else begin
      cx = dl.lx.ovf || (dl.lx.q > 17'd32767);
      rx = cx ? 16'h7fff : dl.lx.q[15:0];
    end
    if (dl.ly.neg) begin
      cy = dl.ly.ovf || (dl.ly.q > 17'd32768);
      ry = cy ? 16'h8000 : 16'(-dl.ly.q);
    end else begin
      cy = dl.ly.ovf || (dl.ly.q > 17'd32767);
      ry = cy ? 16'h7fff : dl.ly.q[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[OUTS]) begin
      if (dl.zero) begin
        m_tdata <= '0;
        m_tuser <= 2'b01;
      end else begin
        m_tdata <= {ry, rx};
        m_tuser <= {cx || cy, 1'b0};
      end
    end
  end

  assign m_tvalid = vld[NST-1];

endmodule
